FILE: sv/frs_pkg.sv
// Package for the frequency residency statistics block.
// Holds the item command codes, slot constants, controller states and the
// command/status structs shared by the controller, datapath and top level.
package frs_pkg;

   // Number of frequency slot registers and the code for an unknown slot.
   localparam int unsigned SLOT_REGS  = 8;
   localparam int unsigned CFG_IDX_W  = 3;
   localparam int unsigned FREQ_W     = 32;
   localparam int unsigned SLOT_W     = 4;
   localparam logic [SLOT_W-1:0] UNKNOWN_SLOT = 4'd8;

   // Field widths of the stream payloads.
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 136;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_TRANS = 2'd1,
      CMD_START = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;      // latch the incoming item
      logic rd;        // read the counter stores for the latched item
      logic wr;        // write back the incremented counter
      logic start;     // make the matched slot current
      logic load_out;  // load the result register
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type cmd;            // command of the latched item
      logic    cur_known;      // current slot is a known slot
      logic    match_known;    // latched frequency matches a slot
      logic    match_differs;  // matched slot differs from the current one
      logic    out_free;       // result register can take a new result
   } ctl_status_type;

endpackage

FILE: sv/frequency_residency_stats_top.sv
// Top level of the frequency residency statistics block.
// Joins the controller (frs_ctrl) and the datapath (frs_dpath); uses frs_pkg.
//
// Software writes the eight frequency slot registers through the csr_ port
// while the block is idle; a zero slot is unused. Items arrive on the req_
// stream: req_tuser carries the command (tick, transition, start, read) and
// req_tdata the frequency and the read row and column. Every item produces
// exactly one result on the rsp_ stream with the counters (read items only),
// the slot in force after the item and the transition-counted flag.
// The controller handles one item at a time. A tick or a counted transition
// loads the result register after the decode and counter read and the
// write-back; start, read and ignored items skip the write-back. The next
// item is accepted once the result is loaded, so a new item is not taken
// before the last one is through the read-modify-write of the residency and
// transition counter stores.
// Reset clears the counter stores via per-entry valid bits at once, zeroes the total count,
// sets the current slot to unknown, clears the slot registers and holds req_tready low.
// When the receiver stalls, the finished result waits in the output register;
// the block still accepts and works on the next item and holds its result
// until the output register frees up.
module frequency_residency_stats_top #(
   parameter int unsigned STATES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [frs_pkg::CFG_IDX_W-1:0]   csr_addr,
   input  logic [frs_pkg::FREQ_W-1:0]      csr_wdata,
   // Item input.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] frequency, [34:32] row_slot, [37:35] col_slot, [39:38] zero
   input  logic [frs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]                      req_tuser,
   // Result output.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [63:0] residency, [95:64] cell_count, [127:96] total_count,
   // [131:128] current_slot, [132] counted, [135:133] zero
   output logic [frs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import frs_pkg::*;

   ctl_cmd_type    ctl;
   ctl_status_type status;

   // Besides the req_ handshake, the state machine only sees the command and status structs.
   frs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctl        (ctl)
   );

   frs_dpath #(
      .STATES (STATES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .ctl        (ctl),
      .status     (status)
   );

endmodule

FILE: sv/frs_ctrl.sv
// Controller state machine of the frequency residency statistics block.
// Runs items through decode, any counter read and write-back, and result.
// Depends on frs_pkg.
module frs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  frs_pkg::ctl_status_type status,
   output frs_pkg::ctl_cmd_type    ctl
);
   import frs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.cmd)
               CMD_TICK: begin
                  state_in = status.cur_known ? ST_WRITE : ST_DONE;
               end
               CMD_TRANS: begin
                  if (status.cur_known && status.match_known && status.match_differs) begin
                     state_in = ST_WRITE;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_WRITE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs. No item is taken while reset is high.
   always_comb begin
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            ctl.take   = req_tvalid && !reset;
         end
         ST_DECODE: begin
            unique case (status.cmd)
               CMD_TICK:  ctl.rd = status.cur_known;
               CMD_TRANS: ctl.rd = status.cur_known && status.match_known
                                   && status.match_differs;
               CMD_START: ctl.start = 1'b1;
               CMD_READ:  ctl.rd = 1'b1;
               default:   ctl.rd = 1'b0;
            endcase
         end
         ST_WRITE: begin
            ctl.wr = 1'b1;
         end
         ST_DONE: begin
            ctl.load_out = status.out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

endmodule

FILE: sv/frs_dpath.sv
// Datapath of the frequency residency statistics block: slot registers,
// slot match, residency and transition counter stores, result register.
// Depends on frs_pkg.
module frs_dpath #(
   parameter int unsigned STATES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [frs_pkg::CFG_IDX_W-1:0]        csr_addr,
   input  logic [frs_pkg::FREQ_W-1:0]           csr_wdata,
   input  logic [frs_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [frs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  frs_pkg::ctl_cmd_type                 ctl,
   output frs_pkg::ctl_status_type              status
);
   import frs_pkg::*;

   localparam int unsigned SW    = $clog2(STATES);
   localparam int unsigned CELLS = STATES * STATES;
   localparam int unsigned MW    = $clog2(CELLS);

   // Configuration.
   logic [FREQ_W-1:0] slot_ff [SLOT_REGS];

   // Latched item.
   cmd_type           cmd_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [2:0]        row_ff;
   logic [2:0]        col_ff;

   // Statistics state.
   logic [SLOT_W-1:0] active_ff;
   logic [31:0]       total_ff;
   logic [SLOT_W-1:0] nxt_ff;
   logic              counted_ff;

   logic [63:0]       res_mem_ff [STATES];
   logic [STATES-1:0] res_vld_ff;
   logic [63:0]       res_rd_ff;
   logic              res_rdv_ff;
   logic [SW-1:0]     res_waddr_ff;

   logic [31:0]       mtx_mem_ff [CELLS];
   logic [CELLS-1:0]  mtx_vld_ff;
   logic [31:0]       mtx_rd_ff;
   logic              mtx_rdv_ff;
   logic [MW-1:0]     mtx_waddr_ff;

   // Result register.
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // Slot match: lowest-numbered nonzero equal slot wins.
   logic [SLOT_W-1:0] match;
   always_comb begin
      match = UNKNOWN_SLOT;
      for (int i = SLOT_REGS - 1; i >= 0; i--) begin
         if ((i < STATES) && (slot_ff[i] != '0) && (slot_ff[i] == freq_ff)) begin
            match = SLOT_W'(i);
         end
      end
   end

   logic [4:0]    active5;
   logic [4:0]    match5;
   logic [4:0]    row5;
   logic [4:0]    col5;
   logic [SW-1:0] active_idx;
   logic [SW-1:0] match_idx;
   logic [SW-1:0] row_idx;
   logic [SW-1:0] col_idx;
   logic          cur_known;
   logic          row_ok;
   logic          col_ok;
   logic [SW-1:0] res_raddr;
   logic [MW-1:0] mtx_raddr;
   logic [63:0]   res_eff;
   logic [31:0]   mtx_eff;

   assign active5    = 5'(active_ff);
   assign match5     = 5'(match);
   assign row5       = 5'(row_ff);
   assign col5       = 5'(col_ff);
   assign active_idx = active5[SW-1:0];
   assign match_idx  = match5[SW-1:0];
   assign row_idx    = row5[SW-1:0];
   assign col_idx    = col5[SW-1:0];
   assign cur_known  = (active_ff < UNKNOWN_SLOT) && (active5 < 5'(STATES));
   assign row_ok     = row5 < 5'(STATES);
   assign col_ok     = col5 < 5'(STATES);

   always_comb begin
      if (cmd_ff == CMD_READ) begin
         res_raddr = row_idx;
         mtx_raddr = MW'(row_idx) * MW'(STATES) + MW'(col_idx);
      end else begin
         res_raddr = active_idx;
         mtx_raddr = MW'(active_idx) * MW'(STATES) + MW'(match_idx);
      end
   end

   // Entries never written read as zero.
   assign res_eff = res_rdv_ff ? res_rd_ff : '0;
   assign mtx_eff = mtx_rdv_ff ? mtx_rd_ff : '0;

   assign status.cmd           = cmd_ff;
   assign status.cur_known     = cur_known;
   assign status.match_known   = match != UNKNOWN_SLOT;
   assign status.match_differs = match != active_ff;
   assign status.out_free      = !rsp_valid_ff || rsp_tready;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_REGS; i++) begin
            slot_ff[i] <= '0;
         end
         active_ff    <= UNKNOWN_SLOT;
         total_ff     <= '0;
         counted_ff   <= 1'b0;
         res_vld_ff   <= '0;
         mtx_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            slot_ff[csr_addr] <= csr_wdata;
         end
         if (ctl.take) begin
            counted_ff <= 1'b0;
         end
         if (ctl.start) begin
            active_ff <= match;
         end
         if (ctl.wr) begin
            if (cmd_ff == CMD_TICK) begin
               res_vld_ff[res_waddr_ff] <= 1'b1;
            end else begin
               mtx_vld_ff[mtx_waddr_ff] <= 1'b1;
               total_ff   <= total_ff + 32'd1;
               active_ff  <= nxt_ff;
               counted_ff <= 1'b1;
            end
         end
         if (ctl.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item latch, counter stores and result payload.
   always_ff @(posedge clock) begin
      if (ctl.take) begin
         cmd_ff  <= cmd_type'(req_tuser);
         freq_ff <= req_tdata[31:0];
         row_ff  <= req_tdata[34:32];
         col_ff  <= req_tdata[37:35];
      end
      if (ctl.rd) begin
         res_rd_ff    <= res_mem_ff[res_raddr];
         res_rdv_ff   <= res_vld_ff[res_raddr];
         res_waddr_ff <= res_raddr;
         mtx_rd_ff    <= mtx_mem_ff[mtx_raddr];
         mtx_rdv_ff   <= mtx_vld_ff[mtx_raddr];
         mtx_waddr_ff <= mtx_raddr;
         nxt_ff       <= match;
      end
      if (ctl.wr) begin
         if (cmd_ff == CMD_TICK) begin
            res_mem_ff[res_waddr_ff] <= res_eff + 64'd1;
         end else begin
            mtx_mem_ff[mtx_waddr_ff] <= mtx_eff + 32'd1;
         end
      end
      // Counters are reported for read items only.
      if (ctl.load_out) begin
         rsp_data_ff <= {3'b000, counted_ff, active_ff,
                         (cmd_ff == CMD_READ) ? total_ff : 32'd0,
                         ((cmd_ff == CMD_READ) && row_ok && col_ok) ? mtx_eff : 32'd0,
                         ((cmd_ff == CMD_READ) && row_ok) ? res_eff : 64'd0};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for frequency_residency_stats_top.
// Drives the req_ stream and the slot registers, predicts every rsp_ item in
// SystemVerilog and compares it field by field; depends on frs_pkg and the top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import frs_pkg::*;

   localparam int unsigned NUM_STATES  = 8;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned NUM_PHASES  = 6;
   localparam int unsigned REPORT_MAX  = 10;
   localparam logic [FREQ_W-1:0] F_MAX = 32'hFFFF_FFFF;

   // One result item, unpacked from rsp_tdata.
   typedef struct packed {
      logic [63:0] residency;
      logic [31:0] cell_count;
      logic [31:0] total;
      logic [3:0]  slot;
      logic        counted;
   } stats_rsp_type;

   // One row of the directed table. Rows with a fixed expectation carry the
   // slot and counted flag only, since their counters read back as zero.
   typedef struct {
      cmd_type       cmd;
      logic [31:0]   freq;
      logic [2:0]    row;
      logic [2:0]    col;
      bit            fixed_exp;
      stats_rsp_type want;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CFG_IDX_W-1:0]   csr_addr   = '0;
   logic [FREQ_W-1:0]      csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   frequency_residency_stats_top #(.STATES(NUM_STATES)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the slot registers and of the statistics stores.
   logic [31:0] slot_freq  [SLOT_REGS];
   logic [63:0] tick_count [NUM_STATES];
   logic [31:0] hop_count  [NUM_STATES][NUM_STATES];
   logic [31:0] hop_total;
   logic [3:0]  cur_slot;

   stats_rsp_type pending_rsp [$];

   int unsigned cycle_count  = 0;
   int unsigned errors       = 0;
   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned hops_counted = 0;
   int unsigned reads_issued = 0;

   // When set, neither side idles, so the block runs at its full rate.
   bit          steady       = 1'b0;
   int unsigned stall_left   = 0;

   // The lowest-numbered nonzero slot equal to f wins; zero never matches.
   function automatic logic [3:0] lookup_slot(input logic [31:0] f);
      if (f == 32'd0) return UNKNOWN_SLOT;
      for (int i = 0; i < SLOT_REGS && i < NUM_STATES; i++)
         if (slot_freq[i] == f) return 4'(i);
      return UNKNOWN_SLOT;
   endfunction

   // Applies one accepted item to the shadow stores and returns the result
   // the block must produce for it.
   function automatic stats_rsp_type account_item(input cmd_type cmd,
                                                   input logic [31:0] f,
                                                   input logic [2:0] row,
                                                   input logic [2:0] col);
      stats_rsp_type r;
      logic [3:0]    nxt;
      logic          known;
      r     = '0;
      known = (cur_slot < UNKNOWN_SLOT) && (cur_slot < NUM_STATES);
      case (cmd)
         CMD_TICK: begin
            if (known) tick_count[cur_slot] += 64'd1;
         end
         CMD_TRANS: begin
            nxt = lookup_slot(f);
            // Only a move from a known slot to a different known slot counts.
            if (known && nxt != UNKNOWN_SLOT && nxt != cur_slot) begin
               hop_count[cur_slot][nxt] += 32'd1;
               hop_total += 32'd1;
               cur_slot   = nxt;
               r.counted  = 1'b1;
               hops_counted++;
            end
         end
         CMD_START: begin
            cur_slot = lookup_slot(f);
         end
         default: begin
            if (row < NUM_STATES) begin
               r.residency = tick_count[row];
               if (col < NUM_STATES) r.cell_count = hop_count[row][col];
            end
            r.total = hop_total;
            reads_issued++;
         end
      endcase
      r.slot = cur_slot;
      return r;
   endfunction

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic stim_row_type stim_row(input cmd_type cmd, input logic [31:0] f,
                                             input logic [2:0] row, input logic [2:0] col,
                                             input bit fixed_exp, input logic [3:0] slot,
                                             input logic counted);
      stim_row_type s;
      s.cmd          = cmd;
      s.freq         = f;
      s.row          = row;
      s.col          = col;
      s.fixed_exp    = fixed_exp;
      s.want         = '0;
      s.want.slot    = slot;
      s.want.counted = counted;
      return s;
   endfunction

   // Presents one item after an optional idle gap and waits for the
   // handshake. The expectation is queued at the accepting edge. valid is
   // left high so that a following item can go out back to back.
   task automatic send_item(input cmd_type cmd, input logic [31:0] f, input logic [2:0] row,
                            input logic [2:0] col, input int unsigned gap,
                            input bit fixed_exp, input stats_rsp_type want);
      stats_rsp_type pred;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, col, row, f};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      pred = account_item(cmd, f, row, col);
      pending_rsp.push_back(fixed_exp ? want : pred);
      items_sent++;
   endtask

   // Writes all eight slot registers, one per clock, while the block is idle.
   task automatic load_slots(input logic [31:0] setting [SLOT_REGS]);
      for (int i = 0; i < SLOT_REGS; i++) begin
         csr_we       <= 1'b1;
         csr_addr     <= CFG_IDX_W'(i);
         csr_wdata    <= setting[i];
         slot_freq[i]  = setting[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Stops the stream and waits until every result is back, then lets the
   // block settle before returning.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic report_mismatch(input string why, input stats_rsp_type want,
                                  input stats_rsp_type got);
      errors++;
      if (errors <= REPORT_MAX) begin
         $display("ERROR at cycle %0d: %s", cycle_count, why);
         $display("   expected res=%0h cell=%0h total=%0h slot=%0d counted=%0b",
                  want.residency, want.cell_count, want.total, want.slot, want.counted);
         $display("   actual   res=%0h cell=%0h total=%0h slot=%0d counted=%0b",
                  got.residency, got.cell_count, got.total, got.slot, got.counted);
      end
   endtask

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Result side: random back-pressure, with a few long stalls.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!steady && $urandom_range(0, 99) < 30) begin
         rsp_tready <= 1'b0;
         stall_left <= ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 40);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted result is checked against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      stats_rsp_type got;
      stats_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.residency  = rsp_tdata[63:0];
         got.cell_count = rsp_tdata[95:64];
         got.total      = rsp_tdata[127:96];
         got.slot       = rsp_tdata[131:128];
         got.counted    = rsp_tdata[132];
         results_seen++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with no item outstanding", '0, got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.residency !== want.residency || got.cell_count !== want.cell_count ||
                got.total !== want.total || got.slot !== want.slot ||
                got.counted !== want.counted)
               report_mismatch("result fields differ", want, got);
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_rsp.size());
      $display("frequency_residency_stats_top: mismatch");
      $finish;
   end

   initial begin : run
      stim_row_type dir_tab [$];
      logic [31:0]  setting [SLOT_REGS];
      int unsigned  phase_items [NUM_PHASES];
      int unsigned  r;
      cmd_type      cmd;
      logic [31:0]  f;

      // Reset state of the shadow copy: counters clear, slot unknown.
      foreach (slot_freq[i]) slot_freq[i] = '0;
      foreach (tick_count[i]) tick_count[i] = '0;
      foreach (hop_count[i, j]) hop_count[i][j] = '0;
      hop_total = '0;
      cur_slot  = UNKNOWN_SLOT;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed setting: slot 2 unused, slot 3 duplicates slot 0, slot 4 at
      // the top of the frequency range and slot 5 at the bottom.
      setting = '{32'd100, 32'd200, 32'd0, 32'd100, F_MAX, 32'd1, 32'd300, 32'd400};

      // Reads straight after reset see empty stores and an unknown slot.
      dir_tab.push_back(stim_row(CMD_READ,  32'd0,   3'd0, 3'd0, 1, UNKNOWN_SLOT, 0));
      dir_tab.push_back(stim_row(CMD_READ,  F_MAX,   3'd7, 3'd7, 1, UNKNOWN_SLOT, 0));
      // With no slot in force, ticks are dropped and transitions ignored.
      dir_tab.push_back(stim_row(CMD_TICK,  32'd0,   3'd0, 3'd0, 1, UNKNOWN_SLOT, 0));
      dir_tab.push_back(stim_row(CMD_TRANS, 32'd100, 3'd0, 3'd0, 1, UNKNOWN_SLOT, 0));
      // Zero never matches, and neither does a frequency outside the table.
      dir_tab.push_back(stim_row(CMD_START, 32'd0,   3'd0, 3'd0, 1, UNKNOWN_SLOT, 0));
      dir_tab.push_back(stim_row(CMD_START, 32'd555, 3'd0, 3'd0, 1, UNKNOWN_SLOT, 0));
      // 100 sits in slots 0 and 3; the lower one wins.
      dir_tab.push_back(stim_row(CMD_START, 32'd100, 3'd0, 3'd0, 1, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_TICK,  32'd0,   3'd0, 3'd0, 1, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_TICK,  F_MAX,   3'd7, 3'd7, 1, 4'd0, 0));
      // Same slot, unknown target and zero target are all ignored.
      dir_tab.push_back(stim_row(CMD_TRANS, 32'd100,   3'd0, 3'd0, 1, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_TRANS, 32'd12345, 3'd0, 3'd0, 1, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_TRANS, 32'd0,     3'd0, 3'd0, 1, 4'd0, 0));
      // Counted moves to the slots at both ends of the frequency range.
      dir_tab.push_back(stim_row(CMD_TRANS, F_MAX,   3'd0, 3'd0, 1, 4'd4, 1));
      dir_tab.push_back(stim_row(CMD_TICK,  32'd0,   3'd0, 3'd0, 1, 4'd4, 0));
      dir_tab.push_back(stim_row(CMD_TRANS, 32'd1,   3'd0, 3'd0, 1, 4'd5, 1));
      dir_tab.push_back(stim_row(CMD_TRANS, 32'd200, 3'd0, 3'd0, 0, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_TICK,  32'd0,   3'd0, 3'd0, 0, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_TRANS, 32'd100, 3'd0, 3'd0, 0, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_READ,  32'd0,   3'd0, 3'd4, 0, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_READ,  32'd0,   3'd4, 3'd5, 0, 4'd0, 0));
      dir_tab.push_back(stim_row(CMD_READ,  32'd0,   3'd5, 3'd1, 0, 4'd0, 0));
      // An unknown start drops the slot in force again.
      dir_tab.push_back(stim_row(CMD_START, 32'd7,   3'd0, 3'd0, 1, UNKNOWN_SLOT, 0));
      dir_tab.push_back(stim_row(CMD_TICK,  32'd0,   3'd0, 3'd0, 1, UNKNOWN_SLOT, 0));
      dir_tab.push_back(stim_row(CMD_TRANS, 32'd300, 3'd0, 3'd0, 1, UNKNOWN_SLOT, 0));
      dir_tab.push_back(stim_row(CMD_READ,  F_MAX,   3'd1, 3'd0, 0, 4'd0, 0));

      load_slots(setting);
      foreach (dir_tab[i])
         send_item(dir_tab[i].cmd, dir_tab[i].freq, dir_tab[i].row, dir_tab[i].col,
                   pick_gap(), dir_tab[i].fixed_exp, dir_tab[i].want);
      drain();

      // Random phases, each under its own slot setting. The all-zero setting
      // matches nothing, so it gets fewer items.
      phase_items = '{0, 180, 150, 60, 200, 210};
      for (int p = 1; p < NUM_PHASES; p++) begin
         for (int i = 0; i < SLOT_REGS; i++) begin
            r = $urandom_range(0, 99);
            case (p)
               1: setting[i] = 32'(i + 1);
               2: setting[i] = (i == SLOT_REGS - 1) ? 32'd1 : F_MAX;
               3: setting[i] = 32'd0;
               4: begin
                  // Some unused slots and some duplicates of lower slots.
                  if (r < 20)
                     setting[i] = 32'd0;
                  else if (r < 45 && i > 0)
                     setting[i] = setting[$urandom_range(0, i - 1)];
                  else
                     setting[i] = $urandom();
               end
               default: setting[i] = $urandom() | 32'd1;
            endcase
         end
         load_slots(setting);

         for (int k = 0; k < phase_items[p]; k++) begin
            // Now and then a stretch where neither side idles.
            if (k % 40 == 0) steady <= ($urandom_range(0, 3) == 0);
            r   = $urandom_range(0, 99);
            cmd = (r < 35) ? CMD_TICK : (r < 70) ? CMD_TRANS : (r < 78) ? CMD_START
                                                                        : CMD_READ;
            // Mostly frequencies from the table so that moves are counted.
            r = $urandom_range(0, 99);
            if (r < 70)      f = slot_freq[$urandom_range(0, SLOT_REGS - 1)];
            else if (r < 78) f = 32'd0;
            else             f = $urandom();
            send_item(cmd, f, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      pick_gap(), 0, '0);
         end
         steady <= 1'b0;
         drain();
      end

      $display("Ran %0d items over %0d slot settings: %0d counted transitions, %0d reads.",
               items_sent, NUM_PHASES, hops_counted, reads_issued);
      $display("Checked %0d results in %0d cycles, %0d mismatches.",
               results_seen, cycle_count, errors);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("frequency_residency_stats_top: match");
      else
         $display("frequency_residency_stats_top: mismatch");
      $finish;
   end

endmodule
